// File: design/gbns_pkg.sv
package gbns_pkg;

  // Cap on outstanding packets. Credits and free_credits are 8 bits wide.
  localparam int unsigned MAX_WINDOW = 128;

  localparam logic [15:0] RESET_PAYLOAD = 16'd1023;
  localparam logic [7:0]  RESET_WINDOW  = 8'd100;
  localparam logic [15:0] RESET_TIMEOUT = 16'd10000;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BYTES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PACKETS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd4;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_SEND  = 2'd1,
    CMD_ACK   = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [31:0] total_bytes;
    logic [31:0] total_packets;
    logic [15:0] max_payload;
    logic [7:0]  window_limit;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic        packet_valid;
    logic [31:0] seq_number;
    logic [31:0] byte_offset;
    logic [15:0] payload_size;
    logic        went_back;
    logic        all_acked;
    logic [7:0]  free_credits;
  } res_t;

endpackage

// File: design/gbns_cfg.sv
module gbns_cfg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [gbns_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [gbns_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output gbns_pkg::cfg_t                        cfg_o
);

  gbns_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_bytes   <= '0;
      cfg_q.total_packets <= '0;
      cfg_q.max_payload   <= gbns_pkg::RESET_PAYLOAD;
      cfg_q.window_limit  <= gbns_pkg::RESET_WINDOW;
      cfg_q.timeout_ticks <= gbns_pkg::RESET_TIMEOUT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gbns_pkg::REG_TOTAL_BYTES:   cfg_q.total_bytes   <= cfg_data_i;
        gbns_pkg::REG_TOTAL_PACKETS: cfg_q.total_packets <= cfg_data_i;
        gbns_pkg::REG_MAX_PAYLOAD:   cfg_q.max_payload   <= cfg_data_i[15:0];
        gbns_pkg::REG_WINDOW_LIMIT:  cfg_q.window_limit  <= cfg_data_i[7:0];
        gbns_pkg::REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/gbns_core.sv
module gbns_core #(
  parameter int unsigned MaxWindow = gbns_pkg::MAX_WINDOW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [1:0]       command_i,
  input  logic [31:0]      ack_number_i,
  input  gbns_pkg::cfg_t   cfg_i,
  output gbns_pkg::res_t   res_o
);

  localparam logic [7:0] CapLimit = (MaxWindow > 255) ? 8'd255 : 8'(MaxWindow);

  logic [31:0] base_seq_q, base_seq_d;
  logic [31:0] next_seq_q, next_seq_d;
  logic [31:0] send_offset_q, send_offset_d;
  logic [31:0] acked_offset_q, acked_offset_d;
  logic [31:0] bytes_unsent_q, bytes_unsent_d;
  logic [31:0] bytes_unacked_q, bytes_unacked_d;
  logic [7:0]  credits_q, credits_d;
  logic [15:0] idle_ticks_q, idle_ticks_d;

  logic [7:0]  cap, room;
  logic        done;
  logic [15:0] send_size;
  logic [31:0] ack_count, ack_tail, ack_min, tick_gap;
  logic [7:0]  ack_give, tick_give;
  logic [47:0] rel_full;
  logic [31:0] ack_rel;
  logic [15:0] idle_inc;
  gbns_pkg::cmd_e cmd;

  assign cmd  = gbns_pkg::cmd_e'(command_i);
  assign cap  = (cfg_i.window_limit < CapLimit) ? cfg_i.window_limit : CapLimit;
  assign room = (credits_q < cap) ? cap - credits_q : 8'd0;
  assign done = base_seq_q >= cfg_i.total_packets;

  assign send_size = (bytes_unsent_q < {16'd0, cfg_i.max_payload}) ?
                     bytes_unsent_q[15:0] : cfg_i.max_payload;

  // Ack path: credits back capped by window room and packets left; bytes released
  // capped by what is still unacked.
  assign ack_count = ack_number_i - base_seq_q + 32'd1;
  assign ack_tail  = cfg_i.total_packets - ack_number_i;
  assign ack_min   = (ack_count < ack_tail) ? ack_count : ack_tail;
  assign ack_give  = (ack_min < {24'd0, room}) ? ack_min[7:0] : room;
  assign rel_full  = ack_count * {16'd0, cfg_i.max_payload};
  assign ack_rel   = (rel_full < {16'd0, bytes_unacked_q}) ? rel_full[31:0] : bytes_unacked_q;

  assign idle_inc  = (idle_ticks_q == 16'hFFFF) ? idle_ticks_q : idle_ticks_q + 16'd1;
  assign tick_gap  = cfg_i.total_packets - base_seq_q;
  assign tick_give = (tick_gap < {24'd0, room}) ? tick_gap[7:0] : room;

  always_comb begin
    base_seq_d      = base_seq_q;
    next_seq_d      = next_seq_q;
    send_offset_d   = send_offset_q;
    acked_offset_d  = acked_offset_q;
    bytes_unsent_d  = bytes_unsent_q;
    bytes_unacked_d = bytes_unacked_q;
    credits_d       = credits_q;
    idle_ticks_d    = idle_ticks_q;
    res_o.packet_valid = 1'b0;
    res_o.seq_number   = '0;
    res_o.byte_offset  = '0;
    res_o.payload_size = '0;
    res_o.went_back    = 1'b0;

    if (cmd == gbns_pkg::CMD_START) begin
      base_seq_d      = '0;
      next_seq_d      = '0;
      send_offset_d   = '0;
      acked_offset_d  = '0;
      bytes_unsent_d  = cfg_i.total_bytes;
      bytes_unacked_d = cfg_i.total_bytes;
      credits_d       = (cfg_i.total_packets < {24'd0, cap}) ?
                        cfg_i.total_packets[7:0] : cap;
      idle_ticks_d    = '0;
    end else if (!done) begin
      case (cmd)
        gbns_pkg::CMD_SEND: begin
          if (credits_q != 8'd0) begin
            credits_d = credits_q - 8'd1;
            if (bytes_unsent_q != 32'd0) begin
              res_o.packet_valid = 1'b1;
              res_o.seq_number   = next_seq_q;
              res_o.byte_offset  = send_offset_q;
              res_o.payload_size = send_size;
              send_offset_d  = send_offset_q + {16'd0, send_size};
              bytes_unsent_d = bytes_unsent_q - {16'd0, send_size};
              next_seq_d     = next_seq_q + 32'd1;
            end
          end
        end
        gbns_pkg::CMD_ACK: begin
          if (ack_number_i >= base_seq_q && ack_number_i < cfg_i.total_packets) begin
            credits_d       = credits_q + ack_give;
            bytes_unacked_d = bytes_unacked_q - ack_rel;
            acked_offset_d  = acked_offset_q + ack_rel;
            base_seq_d      = ack_number_i + 32'd1;
            idle_ticks_d    = '0;
          end
        end
        gbns_pkg::CMD_TICK: begin
          idle_ticks_d = idle_inc;
          if (idle_inc >= cfg_i.timeout_ticks) begin
            next_seq_d      = base_seq_q;
            send_offset_d   = acked_offset_q;
            bytes_unsent_d  = bytes_unacked_q;
            credits_d       = credits_q + tick_give;
            idle_ticks_d    = '0;
            res_o.went_back = 1'b1;
          end
        end
        default: ;
      endcase
    end

    res_o.all_acked    = base_seq_d >= cfg_i.total_packets;
    res_o.free_credits = credits_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_seq_q      <= '0;
      next_seq_q      <= '0;
      send_offset_q   <= '0;
      acked_offset_q  <= '0;
      bytes_unsent_q  <= '0;
      bytes_unacked_q <= '0;
      credits_q       <= '0;
      idle_ticks_q    <= '0;
    end else if (fire_i) begin
      base_seq_q      <= base_seq_d;
      next_seq_q      <= next_seq_d;
      send_offset_q   <= send_offset_d;
      acked_offset_q  <= acked_offset_d;
      bytes_unsent_q  <= bytes_unsent_d;
      bytes_unacked_q <= bytes_unacked_d;
      credits_q       <= credits_d;
      idle_ticks_q    <= idle_ticks_d;
    end
  end

endmodule

// File: design/go_back_n_sender_window.sv
// Channel   Direction  Handshake               Payload
// -------   ---------  ----------------------  ----------------------------------------
// in        input      in_valid_i / in_stall_o  command_i, ack_number_i
// out       output     out_valid_o / out_stall_i packet_valid_o, seq_number_o, byte_offset_o,
//                                               payload_size_o, went_back_o, all_acked_o,
//                                               free_credits_o
// cfg       input      cfg_we_i                 cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_stall_i is low. An accepted item sits in the input
// register; when it fires, its result is loaded into the result register and out_valid_o
// rises with that load. The window state updates on that same edge, so the next item
// sees it. Reset clears all window counters and loads register defaults; no clearing pass.
// A stall at the output holds the result register and backs up into in_stall_o.
module go_back_n_sender_window #(
  parameter int unsigned MaxWindow = gbns_pkg::MAX_WINDOW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        command_i,
  input  logic [31:0]                       ack_number_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              packet_valid_o,
  output logic [31:0]                       seq_number_o,
  output logic [31:0]                       byte_offset_o,
  output logic [15:0]                       payload_size_o,
  output logic                              went_back_o,
  output logic                              all_acked_o,
  output logic [7:0]                        free_credits_o,
  // register writes
  input  logic                              cfg_we_i,
  input  logic [gbns_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gbns_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  gbns_pkg::cfg_t cfg;
  gbns_pkg::res_t res;
  gbns_pkg::res_t res_q;

  // input register
  logic        in_valid_q;
  logic [1:0]  command_q;
  logic [31:0] ack_number_q;
  logic        out_valid_q;

  // The item in the input register moves on whenever the result register is free or
  // being emptied this cycle.
  logic advance;
  logic fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      command_q    <= command_i;
      ack_number_q <= ack_number_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  gbns_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Window state and the per-command update
  gbns_core #(
    .MaxWindow (MaxWindow)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .command_i    (command_q),
    .ack_number_i (ack_number_q),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  assign out_valid_o    = out_valid_q;
  assign packet_valid_o = res_q.packet_valid;
  assign seq_number_o   = res_q.seq_number;
  assign byte_offset_o  = res_q.byte_offset;
  assign payload_size_o = res_q.payload_size;
  assign went_back_o    = res_q.went_back;
  assign all_acked_o    = res_q.all_acked;
  assign free_credits_o = res_q.free_credits;

endmodule
